// ----- rtl/core/bffa_pkg.sv -----
// Shared constants, types and state codes of the first-fit bitmap allocator.
`default_nettype none
package bffa_pkg;

  // Bitmap geometry
  localparam int MapWords  = 1024;
  localparam int WordBits  = 32;
  localparam int SegBytes  = 128;
  localparam int HdrBytes  = 8;
  localparam int RamBase   = 32'h0010_0000;

  // Derived widths
  localparam int WidxW     = $clog2(MapWords);           // word index
  localparam int BitW      = $clog2(WordBits);           // bit within word
  localparam int SegW      = WidxW + BitW;               // global segment index
  localparam int SegShift  = $clog2(SegBytes);
  localparam int CapShift  = $clog2(SegBytes * WordBits);
  localparam int ReqW      = 16;
  localparam int CntW      = 10;                         // segment count
  localparam int RunW      = CntW + 1;                   // run length in a word
  localparam int AddrW     = 23;
  localparam int CapW      = 23;
  localparam int PfxW      = BitW + 1;                   // last used bit + 1
  localparam int PfxLevels = BitW;

  localparam logic [CapW-1:0] CapLimit = CapW'(MapWords * WordBits * SegBytes);
  localparam int              ReqPad   = HdrBytes + SegBytes - 1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_DONE
  } state_e;

  // Status from the word scanner to the sequencer
  typedef struct packed {
    logic            found;   // run located, start is valid
    logic            pend;    // a word is still in the evaluate stage
    logic [SegW-1:0] start;   // first segment of the run
  } scan_res_t;

endpackage
`default_nettype wire

// ----- rtl/core/bitmap_first_fit_allocator_core.sv -----
// Top level: sequencer, bitmap RAM and word scanner of the first-fit allocator.
// A zero-size request goes straight to the result; otherwise the scanner reads the
//   capacity words (all of them, or through the hit), then marks the run's words (up to 17).
// One request at a time; busy_o is high from the transfer and low again in the result
//   cycle. Reset: a clearing pass over every bitmap word with busy_o high; capacity and
//   free count reset to zero. Results cannot be stalled.
`default_nettype none
module bitmap_first_fit_allocator_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output      logic                        busy_o,
  input  wire logic [bffa_pkg::ReqW-1:0]   request_bytes_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [bffa_pkg::CapW-1:0]   cfg_wdata_i,
  output      logic                        done_o,
  output      logic                        ok_o,
  output      logic [bffa_pkg::AddrW-1:0]  address_o,
  output      logic [bffa_pkg::CntW-1:0]   segment_count_o,
  output      logic [bffa_pkg::CapW-1:0]   free_bytes_o
);
  import bffa_pkg::*;

  state_e state_q, state_d;

  logic [WidxW-1:0]  clr_q;
  logic [WidxW:0]    cap_words_q;
  logic [CapW-1:0]   free_q;
  logic [CntW-1:0]   seg_cnt_q;
  logic              zero_req_q;
  logic [WidxW:0]    scan_addr_q;
  logic              rd_scan_q;
  logic [WidxW-1:0]  rd_idx_q;
  logic [WidxW:0]    mark_addr_q;
  logic              mark_v_q;
  logic [WidxW-1:0]  mark_widx_q;
  logic              done_q, ok_q;
  logic [AddrW-1:0]  addr_q;
  logic [CntW-1:0]   segcnt_q;
  logic [CapW-1:0]   free_out_q;

  logic              accept;
  logic              scan_issue, mark_issue;
  logic              ram_we, ram_re;
  logic [WidxW-1:0]  ram_waddr, ram_raddr;
  logic [WordBits-1:0] ram_wdata, ram_rdata;
  scan_res_t         scan_res;

  logic [ReqW:0]     req_pad;
  logic [CntW-1:0]   req_segs;
  logic [CapW-1:0]   cap_sat;
  logic [SegW-1:0]   end_seg;
  logic [WidxW-1:0]  w0, w1;
  logic [BitW-1:0]   lo_bit, hi_bit;
  logic [WordBits-1:0] mark_mask;
  logic [CntW+SegShift-1:0] taken;
  logic [CapW-1:0]   free_new;
  logic [AddrW-1:0]  addr_new;

  // Request size to segment count, header included
  assign req_pad  = (ReqW+1)'(request_bytes_i) + (ReqW+1)'(ReqPad);
  assign req_segs = CntW'(req_pad >> SegShift);

  // Capacity saturates at what the bitmap covers
  assign cap_sat = (cfg_wdata_i > CapLimit) ? CapLimit : cfg_wdata_i;

  // Run bounds for marking
  assign end_seg = scan_res.start + SegW'(seg_cnt_q) - SegW'(1);
  assign w0      = scan_res.start[SegW-1:BitW];
  assign w1      = end_seg[SegW-1:BitW];
  assign lo_bit  = (mark_widx_q == w0) ? scan_res.start[BitW-1:0] : '0;
  assign hi_bit  = (mark_widx_q == w1) ? end_seg[BitW-1:0] : BitW'(WordBits - 1);
  assign mark_mask = ({WordBits{1'b1}} << lo_bit) &
                     ({WordBits{1'b1}} >> (BitW'(WordBits - 1) - hi_bit));

  // Result arithmetic
  assign taken    = {seg_cnt_q, {SegShift{1'b0}}};
  assign free_new = (free_q > CapW'(taken)) ? (free_q - CapW'(taken)) : '0;
  assign addr_new = AddrW'(RamBase) + AddrW'({scan_res.start, {SegShift{1'b0}}}) +
                    AddrW'(HdrBytes);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == WidxW'(MapWords - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) state_d = (req_segs != '0 && request_bytes_i != '0) ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (scan_res.found) begin
          state_d = S_MARK;
        end else if (scan_addr_q == cap_words_q && !rd_scan_q && !scan_res.pend) begin
          state_d = S_DONE;
        end
      end
      S_MARK: begin
        if (mark_addr_q > (WidxW+1)'(w1) && !mark_v_q) state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs and RAM port muxing
  always_comb begin
    accept     = (state_q == S_IDLE) && start_i;
    scan_issue = (state_q == S_SCAN) && (scan_addr_q < cap_words_q) && !scan_res.found;
    mark_issue = (state_q == S_MARK) && (mark_addr_q <= (WidxW+1)'(w1));
    ram_re     = scan_issue || mark_issue;
    ram_raddr  = (state_q == S_MARK) ? mark_addr_q[WidxW-1:0] : scan_addr_q[WidxW-1:0];
    ram_we     = 1'b0;
    ram_waddr  = mark_widx_q;
    ram_wdata  = ram_rdata | mark_mask;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_MARK: begin
        ram_we = mark_v_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cap_words_q <= '0;
      free_q      <= '0;
      scan_addr_q <= '0;
      rd_scan_q   <= 1'b0;
      mark_addr_q <= '0;
      mark_v_q    <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_scan_q <= scan_issue;
      mark_v_q  <= mark_issue;
      done_q    <= (state_q == S_DONE);
      if (state_q == S_CLEAR) clr_q <= clr_q + WidxW'(1);
      if (accept) scan_addr_q <= '0;
      else if (scan_issue) scan_addr_q <= scan_addr_q + (WidxW+1)'(1);
      if (state_q == S_SCAN) mark_addr_q <= (WidxW+1)'(w0);
      else if (mark_issue) mark_addr_q <= mark_addr_q + (WidxW+1)'(1);
      // capacity write reloads the free counter
      if (cfg_we_i) begin
        cap_words_q <= (WidxW+1)'(cap_sat >> CapShift);
        free_q      <= cap_sat;
      end else if (state_q == S_DONE && scan_res.found) begin
        free_q <= free_new;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seg_cnt_q  <= req_segs;
      zero_req_q <= (request_bytes_i == '0);
    end
    rd_idx_q    <= scan_addr_q[WidxW-1:0];
    mark_widx_q <= mark_addr_q[WidxW-1:0];
    if (state_q == S_DONE) begin
      ok_q       <= scan_res.found;
      addr_q     <= scan_res.found ? addr_new : '0;
      segcnt_q   <= zero_req_q ? '0 : seg_cnt_q;
      free_out_q <= scan_res.found ? free_new : free_q;
    end
  end

  bffa_ram #(
    .Width (WordBits),
    .Depth (MapWords)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bffa_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (accept),
    .word_valid_i (rd_scan_q),
    .word_i       (ram_rdata),
    .word_idx_i   (rd_idx_q),
    .segs_i       (seg_cnt_q),
    .res_o        (scan_res)
  );

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign ok_o            = ok_q;
  assign address_o       = addr_q;
  assign segment_count_o = segcnt_q;
  assign free_bytes_o    = free_out_q;

  // A result strobe always lands with the sequencer back at idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");

  // A granted run carries a nonzero size and address
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ok_o) |-> (segment_count_o != '0 && address_o != '0))
    else $error("granted run with zero size or address");

  // Marking writes stay inside the words the run spans
  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == S_MARK) |-> (ram_waddr >= w0 && ram_waddr <= w1))
    else $error("bitmap write outside the run");

  // Free count only grows through a capacity write
  a_free_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> (free_q <= $past(free_q)))
    else $error("free count grew without a capacity write");

endmodule
`default_nettype wire

// ----- rtl/core/bffa_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module bffa_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/bffa_scan.sv -----
// Word scanner: finds the first run of free segments, one bitmap word per cycle.
`default_nettype none
module bffa_scan (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clear_i,
  input  wire logic                        word_valid_i,
  input  wire logic [bffa_pkg::WordBits-1:0] word_i,
  input  wire logic [bffa_pkg::WidxW-1:0]  word_idx_i,
  input  wire logic [bffa_pkg::CntW-1:0]   segs_i,
  output      bffa_pkg::scan_res_t         res_o
);
  import bffa_pkg::*;

  // Stage A: per lane, (index + 1) of the nearest used bit at or below it
  logic [PfxW-1:0] pfx   [PfxLevels+1][WordBits];
  logic [PfxW-1:0] pre_q [WordBits];
  logic            v2_q;
  logic [WidxW-1:0] idx2_q;

  always_comb begin
    for (int p = 0; p < WordBits; p++) begin
      pfx[0][p] = word_i[p] ? PfxW'(p + 1) : '0;
    end
    for (int l = 0; l < PfxLevels; l++) begin
      for (int p = 0; p < WordBits; p++) begin
        if (p >= (1 << l) && pfx[l][p - (1 << l)] > pfx[l][p]) begin
          pfx[l+1][p] = pfx[l][p - (1 << l)];
        end else begin
          pfx[l+1][p] = pfx[l][p];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_valid_i) begin
      for (int p = 0; p < WordBits; p++) begin
        pre_q[p] <= pfx[PfxLevels][p];
      end
      idx2_q <= word_idx_i;
    end
  end

  // Stage B: run length ending at each lane, carried run from earlier words
  logic [CntW-1:0] run_q;
  logic            found_q;
  logic [SegW-1:0] start_q;
  logic [RunW-1:0] run    [WordBits];
  logic [WordBits-1:0] hit;
  logic            hit_any;
  logic [BitW-1:0] hit_pos;
  logic [SegW-1:0] hit_seg;

  always_comb begin
    for (int p = 0; p < WordBits; p++) begin
      run[p] = RunW'(p + 1) - RunW'(pre_q[p]) +
               ((pre_q[p] == '0) ? RunW'(run_q) : '0);
      hit[p] = (run[p] >= RunW'(segs_i));
    end
  end

  // Lowest lane that completes the run
  always_comb begin
    hit_pos = '0;
    for (int p = WordBits - 1; p >= 0; p--) begin
      if (hit[p]) begin
        hit_pos = BitW'(p);
      end
    end
    hit_any = |hit;
    hit_seg = {idx2_q, hit_pos} + SegW'(1) - SegW'(segs_i);
  end

  // Pipeline control and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      found_q <= 1'b0;
      run_q   <= '0;
    end else begin
      v2_q <= word_valid_i && !clear_i;
      if (clear_i) begin
        found_q <= 1'b0;
        run_q   <= '0;
      end else if (v2_q && !found_q) begin
        if (hit_any) begin
          found_q <= 1'b1;
        end else begin
          // no hit means the tail run is below the request
          run_q <= run[WordBits-1][CntW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && !found_q && hit_any) begin
      start_q <= hit_seg;
    end
  end

  assign res_o.found = found_q;
  assign res_o.pend  = v2_q;
  assign res_o.start = start_q;

endmodule
`default_nettype wire
